// ===== design/phcc_pkg.sv =====
`default_nettype none

package phcc_pkg;

   localparam int HEADER_BYTES   = 16;
   localparam int MAX_PACK_BYTES = 64 * 1024 * 1024;
   localparam int COUNT_CAP      = MAX_PACK_BYTES + 1;
   localparam int COUNT_W        = $clog2(COUNT_CAP + 1);
   localparam int HDR_IDX_W      = $clog2(HEADER_BYTES);
   localparam int CFG_W          = 16;
   localparam int CSR_INDEX_W    = 1;
   localparam int RSP_DATA_W     = 64;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [7:0] MAGIC_0 = 8'h47;  // G
   localparam logic [7:0] MAGIC_1 = 8'h42;  // B
   localparam logic [7:0] MAGIC_2 = 8'h43;  // C
   localparam logic [7:0] MAGIC_3 = 8'h46;  // F

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MAJOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MINOR = 1'b1;

   localparam logic [CFG_W-1:0] MAJOR_RESET = 16'd1;
   localparam logic [CFG_W-1:0] MINOR_RESET = 16'd0;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_TOO_SHORT = 3'd2,
      ST_BAD_MAGIC = 3'd3,
      ST_BAD_VER   = 3'd4,
      ST_LEN_MISM  = 3'd5,
      ST_CRC_MISM  = 3'd6
   } status_type;

   typedef struct packed {
      logic       final_byte;
      logic [7:0] data_byte;
   } item_type;

   // Reflected CRC-32 update over one byte, LSB first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/pack_header_crc_check_unit.sv =====
`default_nettype none

// Pack header and CRC checker. Bytes of a pack arrive one per beat on the req_
// stream, header first, with tlast on the final byte. The first sixteen bytes are
// the little-endian header (magic "GBCF", major and minor version, payload length,
// expected CRC-32); every later byte runs through the reflected CRC-32. On the
// final byte one beat leaves on the rsp_ stream with the first failing check (too
// large, too short, bad magic, bad version, length mismatch, CRC mismatch) or ok,
// the computed CRC and the payload byte count, and the checker is ready for the
// next pack. The unit takes one byte per clock cycle, except that a final byte
// waits in the input register while the previous result has not been taken. From
// the input register, the byte-wide CRC update and the header checks feed the
// result register. The expected versions are written through the csr_ port (index
// 0 major, 1 minor) only while the unit is idle; the user must keep to this, and
// the unit does not enforce it.
module pack_header_crc_check_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [phcc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [phcc_pkg::CFG_W-1:0]            csr_wdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [7:0]                            req_tdata,   // [7:0] data_byte
   input  wire logic                                  req_tlast,   // final_byte
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [2:0] status, [34:3] computed_crc, [61:35] payload_bytes, [63:62] zero
   output logic [phcc_pkg::RSP_DATA_W-1:0]            rsp_tdata
);

   logic               item_valid;
   phcc_pkg::item_type item;
   logic               take;

   phcc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   phcc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   // A final byte must not pass a result that is still waiting.
   a_final_holds: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.final_byte && rsp_tvalid && !rsp_tready) |-> (!take && !req_tready))
      else $error("final byte overtook a pending result");

   // A pack shorter than the header reports no payload.
   a_short_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == phcc_pkg::ST_TOO_SHORT) |-> (rsp_tdata[61:35] == '0))
      else $error("too-short pack reported payload bytes");

   // An accepted pack never carries more payload than the size limit allows.
   a_ok_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == phcc_pkg::ST_OK) |->
      (rsp_tdata[61:35] <= 27'(phcc_pkg::MAX_PACK_BYTES - phcc_pkg::HEADER_BYTES)))
      else $error("ok status with payload beyond the size limit");
`endif

endmodule

`default_nettype wire

// ===== design/phcc_in_stage.sv =====
`default_nettype none

module phcc_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              take,
   output logic                   item_valid,
   output phcc_pkg::item_type     item
);

   logic               valid_ff;
   logic               valid_in;
   phcc_pkg::item_type item_ff;
   phcc_pkg::item_type item_in;
   logic               accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.data_byte  = req_tdata;
         item_in.final_byte = req_tlast;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== design/phcc_core.sv =====
`default_nettype none

module phcc_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [phcc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [phcc_pkg::CFG_W-1:0]            csr_wdata,
   input  wire logic                                  item_valid,
   input  wire phcc_pkg::item_type                    item,
   output logic                                       take,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [phcc_pkg::RSP_DATA_W-1:0]            rsp_tdata
);

   localparam int CW = phcc_pkg::COUNT_W;

   logic [phcc_pkg::CFG_W-1:0] major_ff, major_in, minor_ff, minor_in;
   logic [CW-1:0]              count_ff, count_in, count_step;
   logic [31:0]                crc_ff, crc_in, crc_step;
   logic [7:0]                 hdr_ff [phcc_pkg::HEADER_BYTES];
   logic [7:0]                 hdr_in [phcc_pkg::HEADER_BYTES];
   logic                       rsp_valid_ff, rsp_valid_in;
   phcc_pkg::status_type       status_ff, status_in;
   logic [31:0]                ccrc_ff, ccrc_in;
   logic [CW-1:0]              payload_ff, payload_in;

   logic        in_header;
   logic        done;
   logic [31:0] crc_final;
   logic [15:0] hdr_major, hdr_minor;
   logic [31:0] hdr_len, hdr_crc;
   logic        magic_ok;

   // Configuration registers.
   always_comb begin
      major_in = major_ff;
      minor_in = minor_ff;
      if (csr_we) begin
         unique case (csr_index)
            phcc_pkg::CSR_EXPECTED_MAJOR: major_in = csr_wdata;
            phcc_pkg::CSR_EXPECTED_MINOR: minor_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // The input stage moves on unless it holds a final byte and a finished result still blocks the output.
   assign take = item_valid && (!item.final_byte || !rsp_valid_ff || rsp_tready);
   assign done = take && item.final_byte;

   assign in_header  = (count_ff < CW'(phcc_pkg::HEADER_BYTES));
   assign count_step = (count_ff != CW'(phcc_pkg::COUNT_CAP)) ? count_ff + CW'(1) : count_ff;
   assign crc_step   = in_header ? crc_ff : phcc_pkg::crc_byte(crc_ff, item.data_byte);
   assign crc_final  = ~crc_step;

   always_comb begin
      for (int i = 0; i < phcc_pkg::HEADER_BYTES; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      if (take && in_header) begin
         hdr_in[count_ff[phcc_pkg::HDR_IDX_W-1:0]] = item.data_byte;
      end
   end

   assign magic_ok  = (hdr_in[0] == phcc_pkg::MAGIC_0) && (hdr_in[1] == phcc_pkg::MAGIC_1) &&
                      (hdr_in[2] == phcc_pkg::MAGIC_2) && (hdr_in[3] == phcc_pkg::MAGIC_3);
   assign hdr_major = {hdr_in[5], hdr_in[4]};
   assign hdr_minor = {hdr_in[7], hdr_in[6]};
   assign hdr_len   = {hdr_in[11], hdr_in[10], hdr_in[9], hdr_in[8]};
   assign hdr_crc   = {hdr_in[15], hdr_in[14], hdr_in[13], hdr_in[12]};

   always_comb begin
      payload_in = (count_step >= CW'(phcc_pkg::HEADER_BYTES)) ?
                   count_step - CW'(phcc_pkg::HEADER_BYTES) : '0;
      ccrc_in    = crc_final;
      if (count_step > CW'(phcc_pkg::MAX_PACK_BYTES)) begin
         status_in = phcc_pkg::ST_TOO_LARGE;
      end else if (count_step < CW'(phcc_pkg::HEADER_BYTES)) begin
         status_in = phcc_pkg::ST_TOO_SHORT;
      end else if (!magic_ok) begin
         status_in = phcc_pkg::ST_BAD_MAGIC;
      end else if (hdr_major != major_ff || hdr_minor != minor_ff) begin
         status_in = phcc_pkg::ST_BAD_VER;
      end else if (hdr_len != {{(32 - CW){1'b0}}, payload_in}) begin
         status_in = phcc_pkg::ST_LEN_MISM;
      end else if (hdr_crc != crc_final) begin
         status_in = phcc_pkg::ST_CRC_MISM;
      end else begin
         status_in = phcc_pkg::ST_OK;
      end
   end

   always_comb begin
      count_in     = count_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (take) begin
         count_in = count_step;
         crc_in   = crc_step;
      end
      if (done) begin
         count_in     = '0;
         crc_in       = phcc_pkg::CRC_INIT;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff     <= phcc_pkg::MAJOR_RESET;
         minor_ff     <= phcc_pkg::MINOR_RESET;
         count_ff     <= '0;
         crc_ff       <= phcc_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      for (int i = 0; i < phcc_pkg::HEADER_BYTES; i++) begin
         hdr_ff[i] <= hdr_in[i];
      end
      if (done) begin
         status_ff  <= status_in;
         ccrc_ff    <= ccrc_in;
         payload_ff <= payload_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(phcc_pkg::RSP_DATA_W - CW - 35){1'b0}}, payload_ff, ccrc_ff, status_ff};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

// Self-checking bench for the pack header and CRC checker. Packs are sent one
// byte per beat on the request stream, and every beat that carries tlast must
// produce exactly one result beat. A local model of the checker tracks the
// header bytes, the byte count and the running CRC. It queues the verdict it
// predicts for each final byte. The result monitor pops that queue and compares
// every field of every result beat.
module tb_top;
   import phcc_pkg::*;

   // The slowest correct run stalls without any beat moving during the long
   // receiver hold-off. The watchdog limit is far longer than that hold-off.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 1000;

   // Header faults that a generated pack can carry, as bits of a mask.
   localparam int FAULT_MAGIC  = 1;
   localparam int FAULT_MAJOR  = 2;
   localparam int FAULT_MINOR  = 4;
   localparam int FAULT_LENGTH = 8;
   localparam int FAULT_CRC    = 16;
   localparam int FAULT_ALL    = 31;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_type;

   typedef struct {
      status_type         status;
      logic [31:0]        crc;
      logic [COUNT_W-1:0] payload;
   } pack_verdict_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]       csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   // Model state: the header bytes of the current pack, the saturating byte
   // count, the running CRC and the two version registers.
   logic [7:0]             hdr_copy [HEADER_BYTES];
   logic [COUNT_W-1:0]     seen_bytes  = '0;
   logic [31:0]            running_crc = CRC_INIT;
   logic [CFG_W-1:0]       cfg_major   = MAJOR_RESET;
   logic [CFG_W-1:0]       cfg_minor   = MINOR_RESET;

   pack_verdict_type       verdicts_due [$];
   logic [7:0]             pack_bytes [$];
   int                     mismatches       = 0;
   int                     burst_left       = 0;
   int                     hold_off_request = 0;

   pack_header_crc_check_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte
      .req_tlast  (req_tlast),   // final_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [2:0] status, [34:3] computed_crc, [61:35] payload_bytes, [63:62] zero
      .rsp_tdata  (rsp_tdata)
   );

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // Reflected CRC-32, one data bit at a time. The feedback bit is the low bit
   // of the register XORed with the incoming data bit.
   function automatic logic [31:0] crc32_advance(logic [31:0] acc, logic [7:0] b);
      logic [31:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ b[k]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // Advances the model by one accepted byte. On a final byte, the verdict is
   // queued and the model returns to the start of a pack.
   function automatic void predict_byte(logic [7:0] b, logic last);
      logic [COUNT_W-1:0] payload;
      pack_verdict_type   v;
      if (seen_bytes < HEADER_BYTES) begin
         hdr_copy[seen_bytes[HDR_IDX_W-1:0]] = b;
      end else begin
         running_crc = crc32_advance(running_crc, b);
      end
      // The count stops one past the size limit, so an oversized pack stays
      // oversized however long it runs.
      if (seen_bytes < COUNT_CAP) begin
         seen_bytes++;
      end
      if (last) begin
         payload   = (seen_bytes >= HEADER_BYTES) ?
                     seen_bytes - COUNT_W'(HEADER_BYTES) : '0;
         v.crc     = ~running_crc;
         v.payload = payload;
         // The checks run in a fixed order, and the first failure wins.
         if (seen_bytes > MAX_PACK_BYTES) begin
            v.status = ST_TOO_LARGE;
         end else if (seen_bytes < HEADER_BYTES) begin
            v.status = ST_TOO_SHORT;
         end else if ({hdr_copy[3], hdr_copy[2], hdr_copy[1], hdr_copy[0]} !=
                      {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0}) begin
            v.status = ST_BAD_MAGIC;
         end else if ({hdr_copy[5], hdr_copy[4]} != cfg_major ||
                      {hdr_copy[7], hdr_copy[6]} != cfg_minor) begin
            v.status = ST_BAD_VER;
         end else if ({hdr_copy[11], hdr_copy[10], hdr_copy[9], hdr_copy[8]} !=
                      32'(payload)) begin
            v.status = ST_LEN_MISM;
         end else if ({hdr_copy[15], hdr_copy[14], hdr_copy[13], hdr_copy[12]} !=
                      v.crc) begin
            v.status = ST_CRC_MISM;
         end else begin
            v.status = ST_OK;
         end
         verdicts_due = {verdicts_due, v};
         seen_bytes  = '0;
         running_crc = CRC_INIT;
      end
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Result monitor. It samples at the rising edge, where a result beat moves.
   always @(posedge clock) begin : verdict_check
      pack_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual 0x%0h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want = verdicts_due.pop_front();
            check_field("status", want.status, rsp_tdata[2:0]);
            check_field("computed_crc", want.crc, rsp_tdata[34:3]);
            check_field("payload_bytes", want.payload, rsp_tdata[61:35]);
            check_field("padding", 32'd0, rsp_tdata[63:62]);
         end
      end
   end

   // Result receiver. It changes its stall pattern at random intervals. It can
   // also be told to hold off for a long stretch, which it counts down itself.
   initial begin : result_sink
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          phase;
      mode      = RX_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS:  rsp_tready <= 1'b1;
               RX_RANDOM:  rsp_tready <= 1'($urandom_range(0, 1));
               RX_PATTERN: rsp_tready <= (phase % 5) < 2;
               default:    rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // The watchdog ends the run if no beat moves on either stream for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: watchdog expired", $time);
      $display("Verification failed");
      $finish;
   end

   // Sends one byte. The sender works in bursts of random length. Between
   // bursts it lowers tvalid for a random gap, which may be zero. Inputs
   // change only at the falling edge, and the beat counts at the first rising
   // edge with tready high.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_byte(b, last);
   endtask

   task automatic send_pack;
      foreach (pack_bytes[i]) begin
         send_byte(pack_bytes[i], i == pack_bytes.size() - 1);
      end
   endtask

   // Builds a pack with a full header and plen random payload bytes. Every
   // header field is correct for the current versions unless the fault mask
   // asks to break it.
   task automatic send_header_pack(input int faults, input int plen);
      logic [7:0]  body [$];
      logic [7:0]  magic [4];
      logic [15:0] major_v;
      logic [15:0] minor_v;
      logic [31:0] len_v;
      logic [31:0] crc_v;
      logic [7:0]  b;
      crc_v = CRC_INIT;
      for (int i = 0; i < plen; i++) begin
         b = 8'($urandom);
         body = {body, b};
         crc_v = crc32_advance(crc_v, b);
      end
      crc_v   = ~crc_v;
      len_v   = plen;
      major_v = cfg_major;
      minor_v = cfg_minor;
      magic   = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
      if (faults & FAULT_MAGIC) begin
         magic[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      end
      if (faults & FAULT_MAJOR) begin
         major_v ^= 16'($urandom_range(1, 65535));
      end
      if (faults & FAULT_MINOR) begin
         minor_v ^= 16'($urandom_range(1, 65535));
      end
      if (faults & FAULT_LENGTH) begin
         len_v ^= (32'($urandom) | 32'h1) << $urandom_range(0, 31);
      end
      if (faults & FAULT_CRC) begin
         crc_v ^= (32'($urandom) | 32'h1) << $urandom_range(0, 31);
      end
      pack_bytes.delete();
      for (int i = 0; i < 4; i++) begin
         pack_bytes = {pack_bytes, magic[i]};
      end
      pack_bytes = {pack_bytes, major_v[7:0]};
      pack_bytes = {pack_bytes, major_v[15:8]};
      pack_bytes = {pack_bytes, minor_v[7:0]};
      pack_bytes = {pack_bytes, minor_v[15:8]};
      for (int i = 0; i < 4; i++) begin
         pack_bytes = {pack_bytes, len_v[8*i +: 8]};
      end
      for (int i = 0; i < 4; i++) begin
         pack_bytes = {pack_bytes, crc_v[8*i +: 8]};
      end
      foreach (body[i]) begin
         pack_bytes = {pack_bytes, body[i]};
      end
      send_pack();
   endtask

   // A pack of n random bytes with no header structure at all.
   task automatic send_raw_pack(input int n);
      pack_bytes.delete();
      repeat (n) pack_bytes = {pack_bytes, 8'($urandom)};
      send_pack();
   endtask

   // Stops offering bytes and waits until every predicted result has come.
   // The extra cycles cover the two-stage pipeline, so the checker is truly
   // idle afterward.
   task automatic drain_results;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_EXPECTED_MAJOR) begin
         cfg_major = value;
      end else begin
         cfg_minor = value;
      end
   endtask

   // The version registers are written only while the checker is idle.
   task automatic set_versions(input logic [CFG_W-1:0] major_v, input logic [CFG_W-1:0] minor_v);
      drain_results();
      write_csr(CSR_EXPECTED_MAJOR, major_v);
      write_csr(CSR_EXPECTED_MINOR, minor_v);
   endtask

   function automatic logic [CFG_W-1:0] pick_version();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CFG_W'($urandom);
      endcase
   endfunction

   // Directed packs with the reset versions. They cover a final mark on the
   // first byte, a pack one byte short of a header, a pack that is exactly
   // one header long, each kind of header fault, and faults that overlap,
   // where the first check in the order must win.
   task automatic test_reset_versions;
      send_byte(8'hFF, 1'b1);
      for (int i = 0; i < 15; i++) begin
         send_byte(8'h00, i == 14);
      end
      send_header_pack(0, 0);
      send_header_pack(0, 5);
      send_header_pack(FAULT_MAGIC, 2);
      send_header_pack(FAULT_MAJOR, 2);
      send_header_pack(FAULT_MINOR, 2);
      send_header_pack(FAULT_LENGTH, 2);
      send_header_pack(FAULT_CRC, 2);
      send_header_pack(FAULT_MAGIC | FAULT_LENGTH, 1);
      send_header_pack(FAULT_LENGTH | FAULT_CRC, 3);
      drain_results();
   endtask

   // Each pairing of the version extremes, with a good pack and with a
   // mismatch on each version.
   task automatic test_version_extremes;
      logic [CFG_W-1:0] majors [4];
      logic [CFG_W-1:0] minors [4];
      majors = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
      minors = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
      for (int i = 0; i < 4; i++) begin
         set_versions(majors[i], minors[i]);
         send_header_pack(0, $urandom_range(0, 6));
         send_header_pack(FAULT_MAJOR, 1);
         send_header_pack(FAULT_MINOR, 1);
      end
      drain_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering short packs. Each one yields a result, so the result register
   // and the input register fill up and the request stream must stall.
   task automatic test_backpressure;
      hold_off_request = 300;
      repeat (8) send_raw_pack($urandom_range(1, 2));
      send_header_pack(0, 4);
      drain_results();
   endtask

   // Random packs in phases with changing versions. The largest share of packs
   // is well formed with random payload. The rest carry random header faults,
   // end early, or are plain noise.
   task automatic test_random_packs;
      int sent;
      int phase_bytes;
      int pick;
      int plen;
      sent        = 0;
      phase_bytes = 0;
      while (sent < RANDOM_BYTES) begin
         if (phase_bytes >= 300) begin
            set_versions(pick_version(), pick_version());
            phase_bytes = 0;
         end else if ($urandom_range(0, 39) == 0) begin
            drain_results();
         end
         pick = $urandom_range(0, 99);
         plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
         if (pick < 8) begin
            send_raw_pack($urandom_range(1, 40));
         end else if (pick < 16) begin
            send_raw_pack($urandom_range(1, HEADER_BYTES - 1));
         end else if (pick < 60) begin
            send_header_pack(0, plen);
         end else begin
            send_header_pack($urandom_range(1, FAULT_ALL), plen);
         end
         sent        += pack_bytes.size();
         phase_bytes += pack_bytes.size();
      end
   endtask

   // Reset is held at the start, and the tests then run in turn. At the end the
   // bench drains the last results, idles once more and reports.
   initial begin : test_sequence
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      test_reset_versions();
      test_version_extremes();
      test_backpressure();
      test_random_packs();
      drain_results();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
